// ----- rtl/memory_drift_step_regression_top_macros.svh -----
// ----------------------------------------------------------------------------
// Memory drift step regression: assertion macros
// Concurrent checks on the top level clock and reset; empty when SYNTH is set.
// ----------------------------------------------------------------------------
`ifndef MEMORY_DRIFT_STEP_REGRESSION_TOP_MACROS_SVH
`define MEMORY_DRIFT_STEP_REGRESSION_TOP_MACROS_SVH

`ifndef SYNTH
`define MDSR_ASSERT(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("mdsr: property failed");
`define MDSR_NEVER(label, expr) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(expr)) \
        else $error("mdsr: forbidden condition seen");
`else
`define MDSR_ASSERT(label, prop)
`define MDSR_NEVER(label, expr)
`endif

`endif

// ----- rtl/mdsr_pkg.sv -----
// ----------------------------------------------------------------------------
// Memory drift step regression package
// Shared widths, defaults, register indexes and the arithmetic unit request.
// ----------------------------------------------------------------------------
package mdsr_pkg;

    localparam int RING_DEPTH_DEF = 256;
    localparam int ACC_W          = 128;

    localparam logic [15:0] STEP_THR_RST = 16'd256;
    localparam logic [8:0]  MIN_SAMP_RST = 9'd8;
    localparam logic [19:0] MIN_SPAN_RST = 20'd4000;

    // 60000 ms per minute times 16 for 1/256 MB from 1/16 MB levels
    localparam logic [ACC_W-1:0] SLOPE_SCALE = ACC_W'(960000);

    localparam logic [1:0] CFG_STEP_THR = 2'd0;
    localparam logic [1:0] CFG_MIN_SAMP = 2'd1;
    localparam logic [1:0] CFG_MIN_SPAN = 2'd2;

    localparam logic OP_MUL = 1'b0;
    localparam logic OP_DIV = 1'b1;

    typedef struct packed {
        logic start;
        logic op;
    } t_md_req;

endpackage

// ----- rtl/mdsr_muldiv.sv -----
// ----------------------------------------------------------------------------
// Shared shift-add multiplier and restoring divider
// One bit per cycle; multiply stops when the multiplier runs out of ones.
// ----------------------------------------------------------------------------
module mdsr_muldiv import mdsr_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_md_req          i_req,
    input  logic [ACC_W-1:0] i_a,
    input  logic [ACC_W-1:0] i_b,
    output logic [ACC_W-1:0] o_res,
    output logic             o_done
);

    localparam int CNT_W = $clog2(ACC_W + 1);

    logic             r_busy;
    logic             r_done;
    logic             r_op;
    logic [ACC_W-1:0] r_acc;
    logic [ACC_W-1:0] r_a;
    logic [ACC_W-1:0] r_b;
    logic [ACC_W-1:0] r_d;
    logic [CNT_W-1:0] r_cnt;

    logic [ACC_W:0]   rem2;
    logic             ge;
    logic [ACC_W:0]   rem_sub;

    assign rem2    = {r_acc, r_a[ACC_W-1]};
    assign ge      = rem2 >= {1'b0, r_d};
    assign rem_sub = rem2 - {1'b0, r_d};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_op   <= i_req.op;
                r_acc  <= '0;
                r_a    <= i_a;
                r_cnt  <= CNT_W'(ACC_W);
                if (i_req.op == OP_DIV) begin
                    r_b <= '0;
                    r_d <= i_b;
                end else begin
                    r_b <= i_b;
                end
            end else if (r_busy) begin
                if (r_op == OP_MUL) begin
                    if (r_b == '0) begin
                        r_busy <= 1'b0;
                        r_done <= 1'b1;
                    end else begin
                        if (r_b[0]) begin
                            r_acc <= r_acc + r_a;
                        end
                        r_a <= r_a << 1;
                        r_b <= r_b >> 1;
                    end
                end else begin
                    if (r_cnt == '0) begin
                        r_busy <= 1'b0;
                        r_done <= 1'b1;
                    end else begin
                        // shift in next numerator bit, subtract when it fits
                        r_acc <= ge ? rem_sub[ACC_W-1:0] : rem2[ACC_W-1:0];
                        r_a   <= r_a << 1;
                        r_b   <= {r_b[ACC_W-2:0], ge};
                        r_cnt <= r_cnt - 1'b1;
                    end
                end
            end
        end
    end

    assign o_res  = (r_op == OP_DIV) ? r_b : r_acc;
    assign o_done = r_done;

endmodule

// ----- rtl/memory_drift_step_regression_top.sv -----
// ----------------------------------------------------------------------------
// Memory drift step regression
// Sample ring with step search and least-squares RAM/VRAM drift slopes.
// ----------------------------------------------------------------------------
// A push (func 0) is taken while idle and busy stays low. A query (func 1)
// raises busy and, when done, shows its result for exactly one cycle under
// o_res_strobe; the receiver cannot stall it. A query over n stored samples
// with m samples after the latest step walks all n, then the last m, through
// the sample memory, then runs the shared bit-serial multiply/divide unit for
// at most eight products and two divisions. Too few samples sends a query
// straight to its result. The ring needs no clearing after reset.
`include "memory_drift_step_regression_top_macros.svh"

module memory_drift_step_regression_top import mdsr_pkg::*; #(
    parameter int RING_DEPTH = RING_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               i_func,
    input  logic [31:0]        i_sample_time_ms,
    input  logic [27:0]        i_ram_level,
    input  logic [27:0]        i_vram_level,
    output logic               o_res_strobe,
    output logic               o_verdict_valid,
    output logic               o_has_step,
    output logic signed [28:0] o_step_ram_delta,
    output logic signed [28:0] o_step_vram_delta,
    output logic [31:0]        o_step_age_ms,
    output logic signed [31:0] o_ram_slope,
    output logic signed [31:0] o_vram_slope,
    output logic [31:0]        o_span_ms,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [19:0]        i_cfg_data
);

    localparam int IDX_W = $clog2(RING_DEPTH);
    localparam int CNT_W = $clog2(RING_DEPTH + 1);
    localparam int CMP_W = (CNT_W > 9) ? CNT_W : 9;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_P1_RD  = 4'd1;
    localparam logic [3:0] S_P1_USE = 4'd2;
    localparam logic [3:0] S_CHK    = 4'd3;
    localparam logic [3:0] S_P2_RD  = 4'd4;
    localparam logic [3:0] S_P2_X   = 4'd5;
    localparam logic [3:0] S_M0     = 4'd6;
    localparam logic [3:0] S_M1     = 4'd7;
    localparam logic [3:0] S_M2     = 4'd8;
    localparam logic [3:0] S_M3     = 4'd9;
    localparam logic [3:0] S_CALL   = 4'd10;
    localparam logic [3:0] S_WAIT   = 4'd11;
    localparam logic [3:0] S_OUT    = 4'd12;

    localparam logic [2:0] ST_SXX_M  = 3'd0;
    localparam logic [2:0] ST_SX_SX  = 3'd1;
    localparam logic [2:0] ST_SXY_M  = 3'd2;
    localparam logic [2:0] ST_SX_SY  = 3'd3;
    localparam logic [2:0] ST_SCALE  = 3'd4;
    localparam logic [2:0] ST_DIV    = 3'd5;

    // sample memories
    logic [31:0] mem_t [RING_DEPTH];
    logic [27:0] mem_r [RING_DEPTH];
    logic [27:0] mem_v [RING_DEPTH];

    logic [31:0] r_rd_t;
    logic [27:0] r_rd_r;
    logic [27:0] r_rd_v;

    logic [15:0] r_step_thr;
    logic [8:0]  r_min_samp;
    logic [19:0] r_min_span;

    logic [3:0]       r_state;
    logic [3:0]       n_state;
    logic [IDX_W-1:0] r_head;
    logic [CNT_W-1:0] r_fill;
    logic [IDX_W-1:0] r_addr;
    logic [IDX_W-1:0] r_saddr;
    logic [CNT_W-1:0] r_n;
    logic [CNT_W-1:0] r_i;
    logic [CNT_W-1:0] r_start;
    logic [CNT_W-1:0] r_m;
    logic             r_first;
    logic [27:0]      r_prev_r;
    logic [27:0]      r_prev_v;
    logic [31:0]      r_tlast;
    logic [31:0]      r_ts;
    logic [31:0]      r_t0;
    logic [31:0]      r_x;
    logic [27:0]      r_y;
    logic [27:0]      r_z;
    logic [63:0]      r_prod;
    logic [2:0]       r_step;
    logic             r_ch;
    logic             r_neg;

    logic [ACC_W-1:0] r_sx, r_sy, r_sz, r_sxx, r_sxy, r_sxz;
    logic [ACC_W-1:0] r_t1, r_den, r_mag, r_num;

    logic               r_verdict;
    logic               r_has_step;
    logic signed [28:0] r_dr;
    logic signed [28:0] r_dv;
    logic [31:0]        r_age;
    logic [31:0]        r_ram_slope;
    logic [31:0]        r_vram_slope;
    logic [31:0]        r_span;

    logic             accept;
    logic             push;
    logic [IDX_W-1:0] head_inc;
    logic [IDX_W-1:0] addr_inc;
    logic [IDX_W-1:0] base;
    logic             too_few;
    logic             last_i;
    logic signed [28:0] dr;
    logic signed [28:0] dv;
    logic [28:0]      adr;
    logic [28:0]      adv;
    logic             is_step;
    logic [CNT_W-1:0] m_cnt;
    logic [31:0]      t0_sel;
    logic [31:0]      x_val;
    logic [31:0]      mul_b;
    logic [31:0]      span_val;

    t_md_req          md_req;
    logic [ACC_W-1:0] md_a;
    logic [ACC_W-1:0] md_b;
    logic [ACC_W-1:0] md_res;
    logic             md_done;

    logic             slope_neg;
    logic [ACC_W-1:0] slope_mag;
    logic [31:0]      q_sat;
    logic [31:0]      slope_val;

    assign accept   = start && !busy;
    assign push     = accept && !i_func;
    assign head_inc = (r_head == IDX_W'(RING_DEPTH - 1)) ? '0 : r_head + 1'b1;
    assign addr_inc = (r_addr == IDX_W'(RING_DEPTH - 1)) ? '0 : r_addr + 1'b1;
    assign base     = (CNT_W'(r_head) >= r_fill)
                    ? IDX_W'(CNT_W'(r_head) - r_fill)
                    : IDX_W'(CNT_W'(r_head) + CNT_W'(RING_DEPTH) - r_fill);
    assign too_few  = (r_fill == '0) || (CMP_W'(r_fill) < CMP_W'(r_min_samp));
    assign last_i   = (r_i == r_n - 1'b1);

    assign dr      = $signed({1'b0, r_rd_r}) - $signed({1'b0, r_prev_r});
    assign dv      = $signed({1'b0, r_rd_v}) - $signed({1'b0, r_prev_v});
    assign adr     = dr[28] ? 29'(-dr) : 29'(dr);
    assign adv     = dv[28] ? 29'(-dv) : 29'(dv);
    assign is_step = (adr > {13'd0, r_step_thr}) || (adv > {13'd0, r_step_thr});
    assign m_cnt   = r_n - r_start;

    assign t0_sel   = r_first ? r_rd_t : r_t0;
    assign x_val    = r_rd_t - t0_sel;
    assign span_val = r_tlast - r_t0;

    always_comb begin
        case (r_state)
            S_M0:    mul_b = r_x;
            S_M1:    mul_b = {4'd0, r_y};
            default: mul_b = {4'd0, r_z};
        endcase
    end

    // operands for the shared unit, by sequence step
    always_comb begin
        md_req.start = (r_state == S_CALL);
        md_req.op    = (r_step == ST_DIV) ? OP_DIV : OP_MUL;
        case (r_step)
            ST_SXX_M: begin
                md_a = r_sxx;
                md_b = ACC_W'(r_m);
            end
            ST_SX_SX: begin
                md_a = r_sx;
                md_b = r_sx;
            end
            ST_SXY_M: begin
                md_a = r_ch ? r_sxz : r_sxy;
                md_b = ACC_W'(r_m);
            end
            ST_SX_SY: begin
                md_a = r_sx;
                md_b = r_ch ? r_sz : r_sy;
            end
            ST_SCALE: begin
                md_a = r_mag;
                md_b = SLOPE_SCALE;
            end
            default: begin
                md_a = r_num;
                md_b = r_den << 1;
            end
        endcase
    end

    mdsr_muldiv u_muldiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (md_req),
        .i_a     (md_a),
        .i_b     (md_b),
        .o_res   (md_res),
        .o_done  (md_done)
    );

    assign slope_neg = r_t1 < md_res;
    assign slope_mag = slope_neg ? md_res - r_t1 : r_t1 - md_res;

    // saturate quotient to the int32 range, then apply the sign
    always_comb begin
        if (r_neg) begin
            q_sat     = (md_res > ACC_W'(32'h8000_0000)) ? 32'h8000_0000 : md_res[31:0];
            slope_val = 32'(-q_sat);
        end else begin
            q_sat     = (md_res > ACC_W'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : md_res[31:0];
            slope_val = q_sat;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept && i_func) begin
                    n_state = too_few ? S_OUT : S_P1_RD;
                end
            end
            S_P1_RD:  n_state = S_P1_USE;
            S_P1_USE: n_state = last_i ? S_CHK : S_P1_RD;
            S_CHK: begin
                n_state = (CMP_W'(m_cnt) < CMP_W'(r_min_samp)) ? S_OUT : S_P2_RD;
            end
            S_P2_RD:  n_state = S_P2_X;
            S_P2_X:   n_state = S_M0;
            S_M0:     n_state = S_M1;
            S_M1:     n_state = S_M2;
            S_M2:     n_state = S_M3;
            S_M3:     n_state = last_i ? S_CALL : S_P2_RD;
            S_CALL:   n_state = S_WAIT;
            S_WAIT: begin
                if (md_done) begin
                    if (r_step == ST_SX_SX && r_t1 == md_res) begin
                        n_state = S_OUT;
                    end else if (r_step == ST_DIV && r_ch) begin
                        n_state = S_OUT;
                    end else begin
                        n_state = S_CALL;
                    end
                end
            end
            S_OUT:    n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // ring write and registered read
    always_ff @(posedge i_clk) begin
        if (push) begin
            mem_t[r_head] <= i_sample_time_ms;
            mem_r[r_head] <= i_ram_level;
            mem_v[r_head] <= i_vram_level;
        end
        r_rd_t <= mem_t[r_addr];
        r_rd_r <= mem_r[r_addr];
        r_rd_v <= mem_v[r_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_head     <= '0;
            r_fill     <= '0;
            r_step_thr <= STEP_THR_RST;
            r_min_samp <= MIN_SAMP_RST;
            r_min_span <= MIN_SPAN_RST;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_STEP_THR: r_step_thr <= i_cfg_data[15:0];
                    CFG_MIN_SAMP: r_min_samp <= i_cfg_data[8:0];
                    CFG_MIN_SPAN: r_min_span <= i_cfg_data;
                    default: ;
                endcase
            end
            if (push) begin
                r_head <= head_inc;
                if (r_fill < CNT_W'(RING_DEPTH)) begin
                    r_fill <= r_fill + 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (accept && i_func) begin
                    r_n          <= r_fill;
                    r_addr       <= base;
                    r_saddr      <= base;
                    r_i          <= '0;
                    r_start      <= '0;
                    r_verdict    <= 1'b0;
                    r_has_step   <= 1'b0;
                    r_dr         <= '0;
                    r_dv         <= '0;
                    r_age        <= '0;
                    r_ram_slope  <= '0;
                    r_vram_slope <= '0;
                    r_span       <= '0;
                end
            end
            S_P1_USE: begin
                if (r_i != '0 && is_step) begin
                    r_has_step <= 1'b1;
                    r_dr       <= dr;
                    r_dv       <= dv;
                    r_ts       <= r_rd_t;
                    r_start    <= r_i;
                    r_saddr    <= r_addr;
                end
                r_prev_r <= r_rd_r;
                r_prev_v <= r_rd_v;
                r_tlast  <= r_rd_t;
                if (!last_i) begin
                    r_i    <= r_i + 1'b1;
                    r_addr <= addr_inc;
                end
            end
            S_CHK: begin
                if (r_has_step) begin
                    r_age <= r_tlast - r_ts;
                end
                r_m     <= m_cnt;
                r_addr  <= r_saddr;
                r_i     <= r_start;
                r_first <= 1'b1;
                r_sx    <= '0;
                r_sy    <= '0;
                r_sz    <= '0;
                r_sxx   <= '0;
                r_sxy   <= '0;
                r_sxz   <= '0;
            end
            S_P2_X: begin
                r_t0    <= t0_sel;
                r_first <= 1'b0;
                r_x     <= x_val;
                r_y     <= r_rd_r;
                r_z     <= r_rd_v;
                r_sx    <= r_sx + ACC_W'(x_val);
                r_sy    <= r_sy + ACC_W'(r_rd_r);
                r_sz    <= r_sz + ACC_W'(r_rd_v);
            end
            S_M0: begin
                r_prod <= r_x * mul_b;
            end
            S_M1: begin
                r_sxx  <= r_sxx + ACC_W'(r_prod);
                r_prod <= r_x * mul_b;
            end
            S_M2: begin
                r_sxy  <= r_sxy + ACC_W'(r_prod);
                r_prod <= r_x * mul_b;
            end
            S_M3: begin
                r_sxz <= r_sxz + ACC_W'(r_prod);
                r_step <= ST_SXX_M;
                r_ch   <= 1'b0;
                if (!last_i) begin
                    r_i    <= r_i + 1'b1;
                    r_addr <= addr_inc;
                end
            end
            S_WAIT: begin
                if (md_done) begin
                    case (r_step)
                        ST_SXX_M: begin
                            r_t1   <= md_res;
                            r_step <= ST_SX_SX;
                        end
                        ST_SX_SX: begin
                            r_den  <= r_t1 - md_res;
                            r_step <= ST_SXY_M;
                        end
                        ST_SXY_M: begin
                            r_t1   <= md_res;
                            r_step <= ST_SX_SY;
                        end
                        ST_SX_SY: begin
                            r_neg  <= slope_neg;
                            r_mag  <= slope_mag;
                            r_step <= ST_SCALE;
                        end
                        ST_SCALE: begin
                            // round half away from zero: (2*mag*k + den) / (2*den)
                            r_num  <= (md_res << 1) + r_den;
                            r_step <= ST_DIV;
                        end
                        default: begin
                            if (r_ch) begin
                                r_vram_slope <= slope_val;
                                r_span       <= span_val;
                                r_verdict    <= span_val > {12'd0, r_min_span};
                            end else begin
                                r_ram_slope <= slope_val;
                                r_ch        <= 1'b1;
                                r_step      <= ST_SXY_M;
                            end
                        end
                    endcase
                end
            end
            default: ;
        endcase
    end

    assign busy              = (r_state != S_IDLE);
    assign o_res_strobe      = (r_state == S_OUT);
    assign o_verdict_valid   = r_verdict;
    assign o_has_step        = r_has_step;
    assign o_step_ram_delta  = r_dr;
    assign o_step_vram_delta = r_dv;
    assign o_step_age_ms     = r_age;
    assign o_ram_slope       = r_ram_slope;
    assign o_vram_slope      = r_vram_slope;
    assign o_span_ms         = r_span;
    assign o_cfg_ready       = 1'b1;

    `MDSR_ASSERT(a_strobe_ends_busy, o_res_strobe |=> !busy)
    `MDSR_ASSERT(a_query_goes_busy, (start && !busy && i_func) |=> busy)
    `MDSR_ASSERT(a_push_stays_idle, (start && !busy && !i_func) |=> !busy)
    `MDSR_NEVER(a_fill_bound, r_fill > CNT_W'(RING_DEPTH))

endmodule

// ----- tb/memory_drift_step_regression_top_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Memory drift step regression testbench
// Pushes memory samples and queries drift verdicts through the start/busy
// port, writes the registers between phases, and checks every verdict field
// against a local least-squares and step-search predictor.
// ----------------------------------------------------------------------------
module memory_drift_step_regression_top_test;
    import mdsr_pkg::*;

    localparam int DEPTH       = 256;
    localparam int CYCLE_LIMIT = 3000000;
    localparam logic FUNC_PUSH  = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;
    localparam logic [1:0] CFG_UNUSED = 2'd3;

    typedef struct packed {
        logic        verdict_valid;
        logic        has_step;
        logic [28:0] step_ram_delta;
        logic [28:0] step_vram_delta;
        logic [31:0] step_age_ms;
        logic [31:0] ram_slope;
        logic [31:0] vram_slope;
        logic [31:0] span_ms;
    } t_drift_verdict;

    typedef struct {
        logic           func;
        logic [31:0]    t_ms;
        logic [27:0]    ram;
        logic [27:0]    vram;
        bit             typed;
        t_drift_verdict verdict;
    } t_sample_row;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic               i_func;
    logic [31:0]        i_sample_time_ms;
    logic [27:0]        i_ram_level;
    logic [27:0]        i_vram_level;
    logic               o_res_strobe;
    logic               o_verdict_valid;
    logic               o_has_step;
    logic signed [28:0] o_step_ram_delta;
    logic signed [28:0] o_step_vram_delta;
    logic [31:0]        o_step_age_ms;
    logic signed [31:0] o_ram_slope;
    logic signed [31:0] o_vram_slope;
    logic [31:0]        o_span_ms;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [1:0]         i_cfg_index;
    logic [19:0]        i_cfg_data;

    memory_drift_step_regression_top u_dut (.*);

    // predictor state
    logic [31:0] time_hist [DEPTH];
    logic [27:0] ram_hist  [DEPTH];
    logic [27:0] vram_hist [DEPTH];
    int          hist_head;
    int          hist_fill;
    logic [15:0] step_thr;
    logic [8:0]  min_samp;
    logic [19:0] min_span;

    t_drift_verdict pending_verdicts[$];
    int             fail_count = 0;
    int             cycle_count = 0;

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic logic [31:0] fit_slope(logic [127:0] a, logic [127:0] b,
                                              logic [127:0] den);
        logic         neg;
        logic [127:0] mag;
        logic [127:0] q;
        neg = a < b;
        mag = neg ? b - a : a - b;
        q   = (mag * 128'd1920000 + den) / (den << 1);
        if (neg) begin
            if (q > 128'h8000_0000) q = 128'h8000_0000;
            return 32'd0 - q[31:0];
        end
        if (q > 128'h7FFF_FFFF) q = 128'h7FFF_FFFF;
        return q[31:0];
    endfunction

    function automatic t_drift_verdict compute_drift_verdict();
        t_drift_verdict r;
        int             n, base, first, idx, pidx, m;
        longint         dr, dv, th;
        logic [31:0]    t_last, t0, x;
        logic [127:0]   sx, sy, sz, sxx, sxy, sxz, den;
        r = '0;
        n = hist_fill;
        if (n == 0 || n < int'(min_samp)) return r;
        base   = (hist_head + DEPTH - n) % DEPTH;
        t_last = time_hist[(base + n - 1) % DEPTH];
        first  = 0;
        th     = longint'(step_thr);
        for (int i = 1; i < n; i++) begin
            idx  = (base + i) % DEPTH;
            pidx = (base + i - 1) % DEPTH;
            dr = longint'(ram_hist[idx]) - longint'(ram_hist[pidx]);
            dv = longint'(vram_hist[idx]) - longint'(vram_hist[pidx]);
            if (dr > th || dr < -th || dv > th || dv < -th) begin
                first             = i;
                r.has_step        = 1'b1;
                r.step_ram_delta  = dr[28:0];
                r.step_vram_delta = dv[28:0];
                r.step_age_ms     = t_last - time_hist[idx];
            end
        end
        m = n - first;
        if (m < int'(min_samp)) return r;
        t0 = time_hist[(base + first) % DEPTH];
        sx = '0; sy = '0; sz = '0; sxx = '0; sxy = '0; sxz = '0;
        for (int i = first; i < n; i++) begin
            idx = (base + i) % DEPTH;
            x   = time_hist[idx] - t0;
            sx  += 128'(x);
            sy  += 128'(ram_hist[idx]);
            sz  += 128'(vram_hist[idx]);
            sxx += 128'(x) * 128'(x);
            sxy += 128'(x) * 128'(ram_hist[idx]);
            sxz += 128'(x) * 128'(vram_hist[idx]);
        end
        den = sxx * 128'(m) - sx * sx;
        if (den == '0) return r;
        r.ram_slope     = fit_slope(sxy * 128'(m), sx * sy, den);
        r.vram_slope    = fit_slope(sxz * 128'(m), sx * sz, den);
        r.span_ms       = t_last - t0;
        r.verdict_valid = r.span_ms > 32'(min_span);
        return r;
    endfunction

    // called at a rising edge; returns at the edge that takes the request
    task automatic issue_request(t_sample_row row);
        int gap;
        gap = $urandom_range(6);
        if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start            <= 1'b1;
        i_func           <= row.func;
        i_sample_time_ms <= row.t_ms;
        i_ram_level      <= row.ram;
        i_vram_level     <= row.vram;
        forever begin
            @(negedge i_clk);
            if (!busy) break;
            @(posedge i_clk);
        end
        @(posedge i_clk);
        if (row.func == FUNC_PUSH) begin
            time_hist[hist_head] = row.t_ms;
            ram_hist[hist_head]  = row.ram;
            vram_hist[hist_head] = row.vram;
            hist_head = (hist_head + 1) % DEPTH;
            if (hist_fill < DEPTH) hist_fill++;
        end else if (row.typed) begin
            pending_verdicts.push_back(row.verdict);
        end else begin
            pending_verdicts.push_back(compute_drift_verdict());
        end
    endtask

    task automatic drain_results();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_verdicts.size() != 0 || busy) @(posedge i_clk);
        // pushes leave no result; give the last one time to settle
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_register(logic [1:0] index, logic [19:0] value);
        int gap;
        gap = $urandom_range(6);
        repeat (gap) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= value;
        forever begin
            @(negedge i_clk);
            if (o_cfg_ready) break;
            @(posedge i_clk);
        end
        @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        case (index)
            CFG_STEP_THR: step_thr = value[15:0];
            CFG_MIN_SAMP: min_samp = value[8:0];
            CFG_MIN_SPAN: min_span = value;
            default: ;
        endcase
    endtask

    always @(posedge i_clk) begin
        t_drift_verdict want;
        if (i_rst_n && o_res_strobe) begin
            if (pending_verdicts.size() == 0) begin
                $error("verdict with none pending");
                fail_count++;
            end else begin
                want = pending_verdicts.pop_front();
                if (o_verdict_valid !== want.verdict_valid) begin
                    $error("verdict_valid exp %0d got %0d", want.verdict_valid,
                           o_verdict_valid);
                    fail_count++;
                end
                if (o_has_step !== want.has_step) begin
                    $error("has_step exp %0d got %0d", want.has_step, o_has_step);
                    fail_count++;
                end
                if (o_step_ram_delta !== want.step_ram_delta) begin
                    $error("step_ram_delta exp %0d got %0d",
                           $signed(want.step_ram_delta), o_step_ram_delta);
                    fail_count++;
                end
                if (o_step_vram_delta !== want.step_vram_delta) begin
                    $error("step_vram_delta exp %0d got %0d",
                           $signed(want.step_vram_delta), o_step_vram_delta);
                    fail_count++;
                end
                if (o_step_age_ms !== want.step_age_ms) begin
                    $error("step_age_ms exp %0d got %0d", want.step_age_ms,
                           o_step_age_ms);
                    fail_count++;
                end
                if (o_ram_slope !== want.ram_slope) begin
                    $error("ram_slope exp %0d got %0d", $signed(want.ram_slope),
                           o_ram_slope);
                    fail_count++;
                end
                if (o_vram_slope !== want.vram_slope) begin
                    $error("vram_slope exp %0d got %0d", $signed(want.vram_slope),
                           o_vram_slope);
                    fail_count++;
                end
                if (o_span_ms !== want.span_ms) begin
                    $error("span_ms exp %0d got %0d", want.span_ms, o_span_ms);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        t_sample_row    plan[$];
        t_sample_row    row;
        t_drift_verdict zero_verdict;
        logic [19:0]    thr_set  [5];
        logic [19:0]    samp_set [5];
        logic [19:0]    span_set [5];
        logic [31:0]    now_ms;
        longint         ram_lvl, vram_lvl, ram_rate, vram_rate;
        int             pick;

        zero_verdict = '0;
        hist_head    = 0;
        hist_fill    = 0;
        step_thr     = STEP_THR_RST;
        min_samp     = MIN_SAMP_RST;
        min_span     = MIN_SPAN_RST;
        i_rst_n          = 1'b0;
        start            = 1'b0;
        i_func           = FUNC_PUSH;
        i_sample_time_ms = '0;
        i_ram_level      = '0;
        i_vram_level     = '0;
        i_cfg_valid      = 1'b0;
        i_cfg_index      = CFG_STEP_THR;
        i_cfg_data       = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty ring, then a wrapped time and full-scale levels with too few samples
        plan.push_back('{FUNC_QUERY, 32'd0, 28'd0, 28'd0, 1'b1, zero_verdict});
        plan.push_back('{FUNC_PUSH, 32'd0, 28'd0, 28'd0, 1'b0, zero_verdict});
        plan.push_back('{FUNC_PUSH, 32'hFFFF_FFFF, 28'hFFF_FFFF, 28'hFFF_FFFF, 1'b0,
                         zero_verdict});
        plan.push_back('{FUNC_QUERY, 32'd0, 28'd0, 28'd0, 1'b1, zero_verdict});
        // negative step back down, then a steady drift to fit
        for (int k = 0; k < 8; k++)
            plan.push_back('{FUNC_PUSH, 32'(1000 * k), 28'(1000 + 10 * k),
                             28'(5000 - 20 * k), 1'b0, zero_verdict});
        plan.push_back('{FUNC_QUERY, 32'd0, 28'd0, 28'd0, 1'b0, zero_verdict});
        // step then a flat time axis
        for (int k = 0; k < 8; k++)
            plan.push_back('{FUNC_PUSH, 32'd50000, 28'(100000 + k), 28'd4000, 1'b0,
                             zero_verdict});
        plan.push_back('{FUNC_QUERY, 32'd0, 28'd0, 28'd0, 1'b0, zero_verdict});
        foreach (plan[i]) issue_request(plan[i]);
        drain_results();

        thr_set  = '{20'd0, 20'd40, 20'($urandom_range(1, 65535)), 20'd1, 20'd65535};
        samp_set = '{20'd2, 20'd16, 20'($urandom_range(2, 40)), 20'd511, 20'd256};
        span_set = '{20'd0, 20'd2000, 20'($urandom_range(20000)), 20'd600000,
                     20'hFFFFF};
        now_ms   = 32'd60000;
        ram_lvl  = 2000000;
        vram_lvl = 500000;
        for (int ph = 0; ph < 5; ph++) begin
            write_register(CFG_STEP_THR, thr_set[ph]);
            write_register(CFG_MIN_SAMP, samp_set[ph]);
            write_register(CFG_MIN_SPAN, span_set[ph]);
            if (ph == 2) write_register(CFG_UNUSED, 20'($urandom));
            ram_rate  = longint'($urandom_range(80)) - 40;
            vram_rate = longint'($urandom_range(40)) - 20;
            for (int it = 0; it < 80; it++) begin
                row  = '{FUNC_PUSH, 32'd0, 28'd0, 28'd0, 1'b0, zero_verdict};
                pick = $urandom_range(99);
                if ($urandom_range(7) == 0) begin
                    row.func = FUNC_QUERY;
                    row.t_ms = $urandom;
                    row.ram  = 28'($urandom);
                    row.vram = 28'($urandom);
                end else if (pick < 6) begin
                    // noise sample anywhere in range
                    row.t_ms = $urandom;
                    row.ram  = 28'($urandom);
                    row.vram = 28'($urandom);
                end else begin
                    now_ms += (pick < 10) ? $urandom : $urandom_range(2000);
                    ram_lvl  += ram_rate + longint'($urandom_range(10)) - 5;
                    vram_lvl += vram_rate + longint'($urandom_range(10)) - 5;
                    if (pick < 14) ram_lvl += longint'($urandom_range(70000)) - 35000;
                    else if (pick < 17)
                        vram_lvl += longint'($urandom_range(70000)) - 35000;
                    if (ram_lvl < 0) ram_lvl = 0;
                    if (ram_lvl > 268435455) ram_lvl = 268435455;
                    if (vram_lvl < 0) vram_lvl = 0;
                    if (vram_lvl > 268435455) vram_lvl = 268435455;
                    row.t_ms = now_ms;
                    row.ram  = 28'(ram_lvl);
                    row.vram = 28'(vram_lvl);
                end
                issue_request(row);
            end
            drain_results();
        end

        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
